[rtl/core/cpg_pkg.sv]
// ----------------------------------------------------------------------------
// cpg_pkg: shared types and constants for the pixel to grayscale converter
// Widths, pixel format codes and the channel bundle between unpack and luma.
// ----------------------------------------------------------------------------
package cpg_pkg;

  localparam int PIXEL_W = 24;
  localparam int GRAY_W  = 8;
  localparam int FMT_W   = 3;

  typedef enum logic [FMT_W-1:0] {
    FMT_RGB565 = 3'd0,
    FMT_YUV422 = 3'd1,
    FMT_YUV420 = 3'd2,
    FMT_GRAY   = 3'd3,
    FMT_RGB888 = 3'd4,
    FMT_RGB444 = 3'd5,
    FMT_RGB555 = 3'd6
  } pix_fmt_t;

  typedef enum logic [1:0] {
    LUMA_RGB    = 2'd0,
    LUMA_BYPASS = 2'd1,
    LUMA_ZERO   = 2'd2
  } luma_mode_t;

  typedef struct packed {
    luma_mode_t        mode;
    logic [GRAY_W-1:0] r;
    logic [GRAY_W-1:0] g;
    logic [GRAY_W-1:0] b;
    logic [GRAY_W-1:0] y;
  } chan_t;

endpackage

[rtl/core/cpg_if.sv]
// ----------------------------------------------------------------------------
// cpg_if: stream channels of the pixel to grayscale converter
// Pixel input channel and gray result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cpg_pix_if
  import cpg_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_bits;
  logic               frame_end;

  modport source (output valid, output pixel_bits, output frame_end, input ready);
  modport sink   (input valid, input pixel_bits, input frame_end, output ready);
endinterface

interface cpg_gray_if
  import cpg_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [GRAY_W-1:0] gray_value;
  logic              frame_end_out;

  modport source (output valid, output gray_value, output frame_end_out, input ready);
  modport sink   (input valid, input gray_value, input frame_end_out, output ready);
endinterface

[rtl/core/cpg_unpack.sv]
// ----------------------------------------------------------------------------
// cpg_unpack: pixel byte unpacking
// Picks the channels out of the raw bytes per format and widens them to 8 bits.
// ----------------------------------------------------------------------------
module cpg_unpack
  import cpg_pkg::*;
(
  input  pix_fmt_t           fmt,
  input  logic [PIXEL_W-1:0] pixel_bits,
  output chan_t              chan
);

  logic [7:0]  b0, b1, b2;
  logic [15:0] sw;
  logic [15:0] le;

  assign b0 = pixel_bits[7:0];
  assign b1 = pixel_bits[15:8];
  assign b2 = pixel_bits[23:16];
  assign sw = {b0, b1};   // RGB565 and RGB555 arrive big-endian
  assign le = {b1, b0};

  always_comb begin
    chan.mode = LUMA_RGB;
    chan.r    = '0;
    chan.g    = '0;
    chan.b    = '0;
    chan.y    = b0;
    case (fmt)
      FMT_RGB565: begin
        chan.r = {sw[15:11], sw[15:13]};
        chan.g = {sw[10:5], sw[10:9]};
        chan.b = {sw[4:0], sw[4:2]};
      end
      FMT_RGB555: begin
        chan.r = {sw[14:10], sw[14:12]};
        chan.g = {sw[9:5], sw[9:7]};
        chan.b = {sw[4:0], sw[4:2]};
      end
      FMT_RGB444: begin
        // nibble * 0x11
        chan.r = {le[3:0], le[3:0]};
        chan.g = {le[15:12], le[15:12]};
        chan.b = {le[11:8], le[11:8]};
      end
      FMT_RGB888: begin
        chan.r = b0;
        chan.g = b1;
        chan.b = b2;
      end
      FMT_YUV422, FMT_YUV420, FMT_GRAY: begin
        chan.mode = LUMA_BYPASS;
      end
      default: begin
        chan.mode = LUMA_ZERO;
      end
    endcase
  end

endmodule

[rtl/core/cpg_luma.sv]
// ----------------------------------------------------------------------------
// cpg_luma: luma weighting
// gray = (2r + 5g + b) >> 3, or the Y byte, or zero for an unknown format.
// ----------------------------------------------------------------------------
module cpg_luma
  import cpg_pkg::*;
(
  input  chan_t             chan,
  output logic [GRAY_W-1:0] gray
);

  // max 2040, fits 11 bits
  logic [GRAY_W+2:0] sum;

  assign sum = {2'b00, chan.r, 1'b0} + {1'b0, chan.g, 2'b00}
             + {3'b000, chan.g} + {3'b000, chan.b};

  always_comb begin
    case (chan.mode)
      LUMA_RGB:    gray = sum[GRAY_W+2:3];
      LUMA_BYPASS: gray = chan.y;
      default:     gray = '0;
    endcase
  end

endmodule

[rtl/core/camera_pixel_to_grayscale.sv]
// ----------------------------------------------------------------------------
// camera_pixel_to_grayscale: camera pixel to 8-bit gray converter
// Input register, unpack and luma logic, result register.
//
//   channel  | dir | handshake     | word
//   in_pix   | in  | valid/ready   | pixel_bits[23:0], frame_end
//   out_gray | out | valid/ready   | gray_value[7:0], frame_end_out
//   cfg      | in  | cfg_we        | cfg_wdata[2:0] = pixel_format
//
// One word per clock unless out_gray stalls; out valid rises as gray_r loads.
// Throughput is set by the two-entry register pipeline; a stalled output holds
// both stages, and in_pix.ready drops when both are full and out_gray.ready is low.
// Synchronous active-low reset clears the stage valids and pixel_format.
// ----------------------------------------------------------------------------
module camera_pixel_to_grayscale
  import cpg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  cpg_pix_if.sink           in_pix,
  cpg_gray_if.source        out_gray,
  input  logic              cfg_we,
  input  logic [FMT_W-1:0]  cfg_wdata
);

  pix_fmt_t           fmt_r;
  logic               in_vld_r;
  logic [PIXEL_W-1:0] pix_r;
  logic               fe_r;
  logic               out_vld_r;
  logic [GRAY_W-1:0]  gray_r;
  logic               fe_out_r;

  logic               in_vld_nxt;
  logic               out_vld_nxt;
  logic               in_ld;
  logic               out_ld;
  chan_t              chan;
  logic [GRAY_W-1:0]  gray;

  assign out_ld        = in_vld_r && (!out_vld_r || out_gray.ready);
  assign in_pix.ready  = !in_vld_r || out_ld;
  assign in_ld         = in_pix.valid && in_pix.ready;

  assign in_vld_nxt  = in_ld || (in_vld_r && !out_ld);
  assign out_vld_nxt = out_ld || (out_vld_r && !out_gray.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r     <= FMT_RGB565;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        fmt_r <= pix_fmt_t'(cfg_wdata);
      end
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ld) begin
      pix_r <= in_pix.pixel_bits;
      fe_r  <= in_pix.frame_end;
    end
    if (out_ld) begin
      gray_r   <= gray;
      fe_out_r <= fe_r;
    end
  end

  cpg_unpack u_unpack (
    .fmt        (fmt_r),
    .pixel_bits (pix_r),
    .chan       (chan)
  );

  cpg_luma u_luma (
    .chan (chan),
    .gray (gray)
  );

  assign out_gray.valid         = out_vld_r;
  assign out_gray.gray_value    = gray_r;
  assign out_gray.frame_end_out = fe_out_r;

`ifndef SYNTHESIS
  // a full input stage that cannot drain must refuse new words
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !out_ld) |-> !in_pix.ready)
    else $error("input stage overrun");

  // result register only fills from a held input word
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_vld_r ##1 out_vld_r) |-> $past(in_vld_r))
    else $error("result without input word");

  // frame marker moves with its pixel
  a_fe_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ld |=> (fe_out_r == $past(fe_r)))
    else $error("frame_end lost between stages");

  // a held input word stays put while blocked
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !out_ld) |=> $stable(pix_r))
    else $error("input word changed while stalled");
`endif

endmodule
